[rtl/mfsr_pkg.sv]
// Package: shared types and constants for the mono framebuffer rasterizer.
`default_nettype none
package mfsr_pkg;
  localparam int MAX_ROW_BYTES = 64;
  localparam int MAX_ROWS      = 256;
  localparam int STORE_BYTES   = MAX_ROW_BYTES * MAX_ROWS;
  localparam int AW            = $clog2(STORE_BYTES);
  localparam int QDEPTH        = 2;

  typedef enum logic [2:0] {
    K_CLEAR = 3'd0, K_PIXEL = 3'd1, K_FILL = 3'd2, K_OUTLINE = 3'd3,
    K_DISC = 3'd4, K_RING = 3'd5, K_READ = 3'd6, K_NONE = 3'd7
  } kind_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [0:0] CFG_ROW_BYTES = 1'b0;
  localparam logic [0:0] CFG_HEIGHT    = 1'b1;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [10:0]        radius;
    logic [10:0]        line_width;
    logic               white;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } out_t;

  // Classified command handed from front to back. Area bounds are clipped
  // and inclusive; empty marks a command that draws nothing.
  typedef struct packed {
    kind_t              kind;
    logic               empty;
    logic signed [17:0] x0;
    logic signed [17:0] x1;
    logic signed [17:0] y0;
    logic signed [17:0] y1;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [17:0] rx;
    logic signed [17:0] ry;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [10:0]        lw;
    logic [21:0]        r2;
    logic [21:0]        rin2;
    logic [1:0]         rd_status;
    logic               white;
  } cmd_t;
endpackage
`default_nettype wire

[rtl/mono_framebuffer_shape_rasterizer.sv]
// Top level: 1-bpp framebuffer drawing engine with config port.
// One command in, one result out. A front stage clips the command and squares
// radii, a two-deep queue holds clipped commands, and the back end walks the
// clipped bounding box with a read-modify-write on the single-port byte store:
// each visited pixel steps through address, read, write and step states, and
// pixels outside a circle skip the write; outlines add a setup state per
// strip. Clear writes whole bytes. After reset the back end zeroes the store
// at one byte per cycle; commands queue behind it meanwhile.
`default_nettype none
module mono_framebuffer_shape_rasterizer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mfsr_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mfsr_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [0:0]     cfg_index,
  input  wire logic [8:0]     cfg_data
);
  import mfsr_pkg::*;

  logic [6:0] row_bytes_r;
  logic [8:0] active_height_r;
  logic [6:0] sb;
  logic [8:0] rows;
  logic       qv, qr, bv, br;
  cmd_t       qd, bd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r     <= 7'd64;
      active_height_r <= 9'd256;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROW_BYTES) row_bytes_r <= cfg_data[6:0];
      else active_height_r <= cfg_data;
    end
  end

  // Saturate register values into the legal range.
  assign sb   = (row_bytes_r == 7'd0) ? 7'd1 :
                (row_bytes_r > 7'(MAX_ROW_BYTES)) ? 7'(MAX_ROW_BYTES) : row_bytes_r;
  assign rows = (active_height_r == 9'd0) ? 9'd1 :
                (active_height_r > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : active_height_r;

  mfsr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .sb, .rows,
    .c_valid(qv), .c_ready(qr), .c_data(qd)
  );
  mfsr_queue u_queue (
    .clk, .rst_n, .wr_valid(qv), .wr_ready(qr), .wr_data(qd),
    .rd_valid(bv), .rd_ready(br), .rd_data(bd)
  );
  mfsr_back u_back (
    .clk, .rst_n, .c_valid(bv), .c_ready(br), .c_data(bd), .sb, .rows,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

[rtl/mfsr_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module mfsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/mfsr_front.sv]
// Front end: registers a command, clips it and squares radii.
`default_nettype none
module mfsr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mfsr_pkg::in_t in_data,
  input  wire logic [6:0]    sb,
  input  wire logic [8:0]    rows,
  output logic               c_valid,
  input  wire logic          c_ready,
  output mfsr_pkg::cmd_t     c_data
);
  import mfsr_pkg::*;

  logic               s1_r, s2_r;
  in_t                in_r;
  logic [21:0]        r2_r, rin2_r;
  logic signed [17:0] pw;
  logic signed [17:0] ph;
  logic [10:0]        rin;
  cmd_t               c;

  assign pw = 18'(sb) <<< 3;
  assign ph = 18'(rows);
  assign rin = (in_r.radius > in_r.line_width) ? in_r.radius - in_r.line_width : 11'd0;

  assign in_ready = !s1_r && !s2_r;
  assign c_valid  = s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
      s2_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) s1_r <= 1'b1;
      if (s1_r) begin
        s1_r <= 1'b0;
        s2_r <= 1'b1;
      end
      if (s2_r && c_ready) s2_r <= 1'b0;
    end
    if (in_valid && in_ready) in_r <= in_data;
    if (s1_r) begin
      r2_r   <= 22'(in_r.radius) * 22'(in_r.radius);
      rin2_r <= 22'(rin) * 22'(rin);
    end
  end

  // Classification; bounds inclusive, already clipped.
  always_comb begin
    logic signed [17:0] xs, ys, xe, ye;
    xs = 18'(in_r.x);
    ys = 18'(in_r.y);
    c = '0;
    c.kind  = kind_t'(in_r.kind);
    c.white = in_r.white;
    c.cx = xs;
    c.cy = ys;
    c.rx = xs;
    c.ry = ys;
    c.w  = in_r.w;
    c.h  = in_r.h;
    c.lw = in_r.line_width;
    c.r2 = r2_r;
    // Only a ring has a hole; a filled disc keeps its center.
    c.rin2 = (kind_t'(in_r.kind) == K_RING) ? rin2_r : '0;
    c.x0 = 18'sd0;
    c.y0 = 18'sd0;
    c.x1 = pw - 18'sd1;
    c.y1 = ph - 18'sd1;
    xe = pw - 18'sd1;
    ye = ph - 18'sd1;
    unique case (kind_t'(in_r.kind))
      K_PIXEL: begin
        c.x0 = xs; c.x1 = xs; c.y0 = ys; c.y1 = ys;
      end
      K_FILL: begin
        xe = xs + 18'(in_r.w) - 18'sd1;
        ye = ys + 18'(in_r.h) - 18'sd1;
        c.x0 = xs; c.x1 = xe; c.y0 = ys; c.y1 = ye;
        c.empty = (in_r.w == 12'd0) || (in_r.h == 12'd0);
      end
      K_OUTLINE: begin
        c.empty = (in_r.w == 12'd0) || (in_r.h == 12'd0) || (in_r.line_width == 11'd0);
      end
      K_DISC, K_RING: begin
        c.x0 = xs - 18'(in_r.radius); c.x1 = xs + 18'(in_r.radius);
        c.y0 = ys - 18'(in_r.radius); c.y1 = ys + 18'(in_r.radius);
        c.empty = (in_r.radius == 11'd0) ||
                  ((kind_t'(in_r.kind) == K_RING) && (in_r.line_width == 11'd0));
      end
      K_READ: begin
        c.rd_status = (xs >= 0 && ys >= 0 && xs < pw && ys < ph) ? ST_READ : ST_OUT;
      end
      default: ;
    endcase
    // Common clip to the active window.
    if (c.x0 < 0) c.x0 = 18'sd0;
    if (c.y0 < 0) c.y0 = 18'sd0;
    if (c.x1 > pw - 18'sd1) c.x1 = pw - 18'sd1;
    if (c.y1 > ph - 18'sd1) c.y1 = ph - 18'sd1;
    if (c.x0 > c.x1 || c.y0 > c.y1) c.empty = 1'b1;
  end

  assign c_data = c;
endmodule
`default_nettype wire

[rtl/mfsr_queue.sv]
// Small command FIFO between front and back.
`default_nettype none
module mfsr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire mfsr_pkg::cmd_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output mfsr_pkg::cmd_t      rd_data
);
  import mfsr_pkg::*;
  localparam int PW = $clog2(QDEPTH);
  cmd_t        q_r [QDEPTH];
  logic [PW:0] cnt_r;
  logic [PW-1:0] wp_r, rp_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (PW+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = q_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
    if (wr) q_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

[rtl/mfsr_back.sv]
// Back end: walks pixels of a command with read-modify-write on the store.
`default_nettype none
module mfsr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           c_valid,
  output logic                c_ready,
  input  wire mfsr_pkg::cmd_t c_data,
  input  wire logic [6:0]     sb,
  input  wire logic [8:0]     rows,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mfsr_pkg::out_t      out_data
);
  import mfsr_pkg::*;

  typedef enum logic [7:0] {
    S_CLR   = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_SETUP = 8'b00000100,
    S_PIX   = 8'b00001000,
    S_RD    = 8'b00010000,
    S_WR    = 8'b00100000,
    S_NEXT  = 8'b01000000,
    S_RESP  = 8'b10000000
  } st_t;

  st_t                st_r;
  cmd_t               c_r;
  logic signed [17:0] px_r, py_r;
  logic signed [17:0] bx0_r, bx1_r, by1_r;
  logic [10:0]        i_r;
  logic [1:0]         strip_r;
  logic [AW-1:0]      addr_r;
  logic [7:0]         mask_r;
  logic               hit;
  logic [21:0]        dx2_r, dy2_r;
  logic               out_valid_r;
  out_t               out_r;
  logic               we;
  logic [7:0]         rdata, wdata;
  logic signed [17:0] pw, ph;

  assign pw = 18'(sb) <<< 3;
  assign ph = 18'(rows);

  // Strip of an outline pass: top, bottom, left, right.
  logic signed [17:0] sx0, sx1, sy0, sy1;
  logic               strip_ok, ring_done;
  always_comb begin
    logic signed [17:0] iw, xs, ys, ww, hh;
    iw = 18'(i_r);
    xs = c_r.rx + iw;
    ys = c_r.ry + iw;
    ww = 18'(c_r.w) - (iw <<< 1);
    hh = 18'(c_r.h) - (iw <<< 1);
    ring_done = (ww <= 0 && hh <= 0) || (i_r >= c_r.lw);
    sx0 = xs; sy0 = ys; sx1 = xs; sy1 = ys;
    strip_ok = 1'b1;
    case (strip_r)
      2'd0: begin sx1 = xs + ww - 18'sd1; strip_ok = ww > 0; end
      2'd1: begin
        sy0 = c_r.ry + 18'(c_r.h) - 18'sd1 - iw; sy1 = sy0;
        sx1 = xs + ww - 18'sd1; strip_ok = ww > 0;
      end
      2'd2: begin sy1 = ys + hh - 18'sd1; strip_ok = hh > 0; end
      default: begin
        sx0 = c_r.rx + 18'(c_r.w) - 18'sd1 - iw; sx1 = sx0;
        sy1 = ys + hh - 18'sd1; strip_ok = hh > 0;
      end
    endcase
    if (sx0 < 0) sx0 = 18'sd0;
    if (sy0 < 0) sy0 = 18'sd0;
    if (sx1 > pw - 18'sd1) sx1 = pw - 18'sd1;
    if (sy1 > ph - 18'sd1) sy1 = ph - 18'sd1;
    if (sx0 > sx1 || sy0 > sy1) strip_ok = 1'b0;
  end

  logic is_clear, full_byte;
  assign is_clear = c_r.kind == K_CLEAR;
  // Clear writes whole bytes; x steps by 8 there.
  assign full_byte = is_clear;

  logic signed [17:0] dxs, dys;
  assign dxs = px_r - c_r.cx;
  assign dys = py_r - c_r.cy;

  always_comb begin
    logic [22:0] d2;
    d2 = 23'(dx2_r) + 23'(dy2_r);
    hit = 1'b1;
    if (c_r.kind == K_DISC || c_r.kind == K_RING)
      hit = (d2 <= 23'(c_r.r2)) && (d2 >= 23'(c_r.rin2));
  end

  // Store zeroing after reset writes one byte per cycle.
  assign we = (st_r == S_WR) || (st_r == S_CLR);
  always_comb begin
    if (st_r == S_CLR) wdata = 8'h00;
    else if (full_byte) wdata = c_r.white ? 8'hFF : 8'h00;
    else if (c_r.white) wdata = rdata | mask_r;
    else wdata = rdata & ~mask_r;
  end

  mfsr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk(clk), .we(we), .addr(addr_r), .wdata(wdata), .rdata(rdata)
  );

  assign c_ready   = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == AW'(STORE_BYTES - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (c_valid) begin
          c_r     <= c_data;
          i_r     <= '0;
          strip_r <= '0;
          st_r    <= S_SETUP;
        end
        S_SETUP: begin
          if (c_r.kind == K_OUTLINE && !c_r.empty) begin
            if (ring_done) st_r <= S_RESP;
            else if (!strip_ok) begin
              strip_r <= strip_r + 2'd1;
              if (strip_r == 2'd3) i_r <= i_r + 11'd1;
            end else begin
              bx0_r <= sx0; bx1_r <= sx1; by1_r <= sy1;
              px_r <= sx0; py_r <= sy0;
              st_r <= S_PIX;
            end
          end else if (c_r.kind == K_READ) begin
            px_r <= c_r.cx; py_r <= c_r.cy;
            st_r <= (c_r.rd_status == ST_READ) ? S_PIX : S_RESP;
          end else if (c_r.empty || c_r.kind == K_NONE) begin
            st_r <= S_RESP;
          end else begin
            bx0_r <= c_r.x0; bx1_r <= c_r.x1; by1_r <= c_r.y1;
            px_r <= c_r.x0; py_r <= c_r.y0;
            st_r <= S_PIX;
          end
        end
        S_PIX: begin
          addr_r <= AW'(py_r[8:0]) * AW'(sb) + AW'(px_r[17:3]);
          mask_r <= 8'h80 >> px_r[2:0];
          dx2_r  <= 22'(36'(dxs) * 36'(dxs));
          dy2_r  <= 22'(36'(dys) * 36'(dys));
          st_r   <= S_RD;
        end
        S_RD: begin
          if (c_r.kind == K_READ) st_r <= S_NEXT;
          else st_r <= hit ? S_WR : S_NEXT;
        end
        S_WR: st_r <= S_NEXT;
        S_NEXT: begin
          if (c_r.kind == K_READ) begin
            st_r <= S_RESP;
          end else if (px_r + (full_byte ? 18'sd8 : 18'sd1) <= bx1_r) begin
            px_r <= px_r + (full_byte ? 18'sd8 : 18'sd1);
            st_r <= S_PIX;
          end else if (py_r < by1_r) begin
            px_r <= bx0_r;
            py_r <= py_r + 18'sd1;
            st_r <= S_PIX;
          end else if (c_r.kind == K_OUTLINE) begin
            strip_r <= strip_r + 2'd1;
            if (strip_r == 2'd3) i_r <= i_r + 11'd1;
            st_r <= S_SETUP;
          end else begin
            st_r <= S_RESP;
          end
        end
        S_RESP: if (!out_valid_r) begin
          out_valid_r     <= 1'b1;
          out_r.status    <= (c_r.kind == K_READ) ? c_r.rd_status : ST_DONE;
          out_r.read_data <= (c_r.kind == K_READ && c_r.rd_status == ST_READ) ? rdata : 8'h00;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_WR |-> $past(st_r) == S_RD)
    else $error("write without read");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DONE |-> out_data.read_data == 8'h00)
    else $error("draw result carries data");
`endif
endmodule
`default_nettype wire
